// ===== hw/rtl/rcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcts_pkg: shared types and constants of the RC triggered step sequencer
// Holds the transaction payload types, the configuration record, the register
// index codes, reset values and the trim helper function.
// ----------------------------------------------------------------------------
package rcts_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Sequence phase counter width: holds the sum of three 16-bit tick counts.
    localparam int PHASE_W = 18;

    // Default module parameters.
    localparam int STOP_ON_SAMPLES_DEF  = 50;
    localparam int STOP_OFF_SAMPLES_DEF = 200;
    localparam int COUNT_WIDTH_DEF      = 16;

    // Reset value of the OFF sample counter.
    localparam int OFF_SAMPLES_RST = 1000;

    // Trim capture constants.
    localparam logic signed [12:0] TRIM_CENTER_US = 13'sd1500;
    localparam logic signed [12:0] TRIM_LIMIT     = 13'sd125;

    // Configuration register reset values.
    localparam logic [11:0]        THRESHOLD_RST     = 12'd1300;
    localparam logic signed [7:0]  MIN_LEVEL_RST     = 8'sd30;
    localparam logic signed [7:0]  MAX_LEVEL_RST     = -8'sd30;
    localparam logic [15:0]        MIN_TICKS_RST     = 16'd150;
    localparam logic [15:0]        MAX_TICKS_RST     = 16'd150;
    localparam logic [15:0]        NEUTRAL_TICKS_RST = 16'd1000;
    localparam logic [7:0]         REPETITIONS_RST   = 8'd2;
    localparam logic [15:0]        START_OFF_RST     = 16'd500;

    // Direct-mode flags after reset: bit 0 elevator, bit 1 rudder, bit 2 throttle.
    localparam logic [2:0] DIRECT_FLAGS_RST  = 3'b110;
    localparam logic [2:0] DIRECT_FLAGS_ALL  = 3'b111;
    localparam logic [2:0] DIRECT_FLAGS_NONE = 3'b000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SWITCH_THRESHOLD = 3'd0,
        CFG_MIN_LEVEL        = 3'd1,
        CFG_MAX_LEVEL        = 3'd2,
        CFG_MIN_TICKS        = 3'd3,
        CFG_MAX_TICKS        = 3'd4,
        CFG_NEUTRAL_TICKS    = 3'd5,
        CFG_REPETITIONS      = 3'd6,
        CFG_START_OFF        = 3'd7
    } cfg_index_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [11:0]       switch_threshold_us;
        logic signed [7:0] min_level;
        logic signed [7:0] max_level;
        logic [15:0]       min_ticks;
        logic [15:0]       max_ticks;
        logic [15:0]       neutral_ticks;
        logic [7:0]        repetitions;
        logic [15:0]       start_off_samples;
    } cfg_t;

    // Input transaction payload: one control tick.
    typedef struct packed {
        logic [11:0] log_switch_us;
        logic [11:0] sequence_switch_us;
        logic [11:0] tracking_switch_us;
        logic [10:0] pitch_us;
        logic [10:0] roll_us;
        logic        logging_active;
    } tick_item_t;

    // Output transaction payload: one result per tick.
    typedef struct packed {
        logic              start_request;
        logic              stop_request;
        logic              tracking_on;
        logic signed [7:0] step_command;
        logic signed [7:0] pitch_trim;
        logic signed [7:0] roll_trim;
        logic              elevator_follows_stick;
        logic              rudder_follows_stick;
        logic              throttle_follows_stick;
    } result_item_t;

    // Stick offset in percent: (width - 1500) / 4 truncated toward zero,
    // saturated to +/-125.
    function automatic logic signed [7:0] trim_of(input logic [10:0] width_us);
        logic signed [12:0] diff;
        logic signed [12:0] quot;
        logic signed [12:0] sat;
        diff = $signed({2'b00, width_us}) - TRIM_CENTER_US;
        // Bias negative values so the arithmetic shift rounds toward zero.
        quot = (diff + (diff[12] ? 13'sd3 : 13'sd0)) >>> 2;
        if (quot > TRIM_LIMIT)
            sat = TRIM_LIMIT;
        else if (quot < -TRIM_LIMIT)
            sat = -TRIM_LIMIT;
        else
            sat = quot;
        return sat[7:0];
    endfunction

endpackage

// ===== hw/rtl/rcts_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcts_stream_if: valid/ready channel
// Carries one payload per transaction; a transaction completes at a rising
// clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface rcts_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== hw/rtl/rc_triggered_step_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_triggered_step_sequencer_unit: RC triggered elevator step sequencer
// Debounces the log switch into start/stop requests and plays a configurable
// min/max/neutral elevator pattern with captured stick trims.
// ----------------------------------------------------------------------------
// The block takes one tick transaction per clock cycle while the result side
// is ready and returns exactly one result transaction per tick, in order. A
// tick is held in an input register, processed combinationally by the state
// logic, and its result is held in an output register, so a result is offered
// once its tick has moved from the input register into the output register.
// The sustained rate is one tick per cycle while the result side is ready.
// Stalls on the result side back up through the output and input registers.
// Write the configuration registers only while no tick is in flight.
// ----------------------------------------------------------------------------
module rc_triggered_step_sequencer_unit #(
    parameter int STOP_ON_SAMPLES  = rcts_pkg::STOP_ON_SAMPLES_DEF,
    parameter int STOP_OFF_SAMPLES = rcts_pkg::STOP_OFF_SAMPLES_DEF,
    parameter int COUNT_WIDTH      = rcts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rcts_stream_if.sink                       tick,
    rcts_stream_if.source                     result,
    input  logic                              cfg_we,
    input  logic [rcts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rcts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rcts_pkg::*;

    cfg_t         cfg_reg;
    logic         in_valid_reg,  in_valid_next;
    tick_item_t   in_data_reg;
    logic         out_valid_reg, out_valid_next;
    result_item_t out_data_reg;
    result_item_t core_result;
    logic         tick_fire;
    logic         advance;

    // Pipeline handshake: the tick moves on when the output register frees up.
    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready  = !in_valid_reg || advance;
    assign tick_fire   = tick.valid && tick.ready;

    assign in_valid_next  = tick_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.switch_threshold_us <= THRESHOLD_RST;
            cfg_reg.min_level           <= MIN_LEVEL_RST;
            cfg_reg.max_level           <= MAX_LEVEL_RST;
            cfg_reg.min_ticks           <= MIN_TICKS_RST;
            cfg_reg.max_ticks           <= MAX_TICKS_RST;
            cfg_reg.neutral_ticks       <= NEUTRAL_TICKS_RST;
            cfg_reg.repetitions         <= REPETITIONS_RST;
            cfg_reg.start_off_samples   <= START_OFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SWITCH_THRESHOLD: cfg_reg.switch_threshold_us <= cfg_wdata[11:0];
                CFG_MIN_LEVEL:        cfg_reg.min_level           <= $signed(cfg_wdata[7:0]);
                CFG_MAX_LEVEL:        cfg_reg.max_level           <= $signed(cfg_wdata[7:0]);
                CFG_MIN_TICKS:        cfg_reg.min_ticks           <= cfg_wdata[15:0];
                CFG_MAX_TICKS:        cfg_reg.max_ticks           <= cfg_wdata[15:0];
                CFG_NEUTRAL_TICKS:    cfg_reg.neutral_ticks       <= cfg_wdata[15:0];
                CFG_REPETITIONS:      cfg_reg.repetitions         <= cfg_wdata[7:0];
                CFG_START_OFF:        cfg_reg.start_off_samples   <= cfg_wdata[15:0];
                default:              cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Valid bits of the input and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (tick_fire)
            in_data_reg <= tick.data;
        if (advance)
            out_data_reg <= core_result;
    end

    // Sequencer state and result logic.
    rcts_core #(
        .STOP_ON_SAMPLES  (STOP_ON_SAMPLES),
        .STOP_OFF_SAMPLES (STOP_OFF_SAMPLES),
        .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .result  (core_result)
    );

endmodule

// ===== hw/rtl/rcts_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcts_core: switch debounce and step sequence state
// Holds the sample counters, sequence position, level, trims and direct-mode
// flags, and computes one result combinationally from one registered tick.
// ----------------------------------------------------------------------------
module rcts_core #(
    parameter int STOP_ON_SAMPLES  = rcts_pkg::STOP_ON_SAMPLES_DEF,
    parameter int STOP_OFF_SAMPLES = rcts_pkg::STOP_OFF_SAMPLES_DEF,
    parameter int COUNT_WIDTH      = rcts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  rcts_pkg::cfg_t         cfg,
    input  rcts_pkg::tick_item_t   item,
    output rcts_pkg::result_item_t result
);
    import rcts_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // State registers.
    logic [COUNT_WIDTH-1:0] on_samples_reg,  on_samples_next;
    logic [COUNT_WIDTH-1:0] off_samples_reg, off_samples_next;
    logic [PHASE_W-1:0]     phase_tick_reg,  phase_tick_next;
    logic [7:0]             repeat_index_reg, repeat_index_next;
    logic signed [7:0]      level_reg,      level_next;
    logic signed [7:0]      pitch_trim_reg, pitch_trim_next;
    logic signed [7:0]      roll_trim_reg,  roll_trim_next;
    logic [2:0]             direct_flags_reg, direct_flags_next;

    logic               log_on;
    logic               seq_on;
    logic               start_req;
    logic               stop_req;
    logic [PHASE_W-1:0] end_min;
    logic [PHASE_W-1:0] end_max;
    logic [PHASE_W-1:0] end_neu;

    // Switch decoding against the common threshold.
    assign log_on = item.log_switch_us > cfg.switch_threshold_us;
    assign seq_on = item.sequence_switch_us > cfg.switch_threshold_us;

    // Phase boundaries of one repetition.
    assign end_min = PHASE_W'(cfg.min_ticks);
    assign end_max = end_min + PHASE_W'(cfg.max_ticks);
    assign end_neu = end_max + PHASE_W'(cfg.neutral_ticks);

    // Next-state logic for one tick.
    always_comb
    begin
        on_samples_next   = on_samples_reg;
        off_samples_next  = off_samples_reg;
        phase_tick_next   = phase_tick_reg;
        repeat_index_next = repeat_index_reg;
        level_next        = level_reg;
        pitch_trim_next   = pitch_trim_reg;
        roll_trim_next    = roll_trim_reg;
        direct_flags_next = direct_flags_reg;
        start_req         = 1'b0;
        stop_req          = 1'b0;

        // Saturating sample counters of the log switch.
        if (log_on)
        begin
            if (on_samples_next != COUNT_MAX)
                on_samples_next = on_samples_next + COUNT_WIDTH'(1);
        end
        else
        begin
            if (off_samples_next != COUNT_MAX)
                off_samples_next = off_samples_next + COUNT_WIDTH'(1);
        end

        // Start and stop requests; start has priority.
        if (log_on && (32'(off_samples_next) > 32'(cfg.start_off_samples)))
        begin
            start_req         = 1'b1;
            on_samples_next   = '0;
            off_samples_next  = '0;
            phase_tick_next   = '0;
            repeat_index_next = '0;
        end
        else if (!log_on && (32'(on_samples_next) > 32'(STOP_ON_SAMPLES))
                 && (32'(off_samples_next) > 32'(STOP_OFF_SAMPLES)))
        begin
            stop_req        = 1'b1;
            on_samples_next = '0;
            level_next      = '0;
        end
        else if (log_on && (32'(on_samples_next) > 32'(STOP_ON_SAMPLES)))
        begin
            off_samples_next = '0;
        end

        // Step sequence; runs only while logging and not on a stop tick.
        if (item.logging_active && !stop_req)
        begin
            if (seq_on)
            begin
                if ((phase_tick_next == '0) && (repeat_index_next == '0))
                begin
                    pitch_trim_next = trim_of(item.pitch_us);
                    roll_trim_next  = trim_of(item.roll_us);
                end
                direct_flags_next = DIRECT_FLAGS_NONE;
                if (repeat_index_next < cfg.repetitions)
                begin
                    if (phase_tick_next < end_min)
                    begin
                        phase_tick_next = phase_tick_next + PHASE_W'(1);
                        level_next      = cfg.min_level;
                    end
                    else if (phase_tick_next < end_max)
                    begin
                        phase_tick_next = phase_tick_next + PHASE_W'(1);
                        level_next      = cfg.max_level;
                    end
                    else if (phase_tick_next < end_neu)
                    begin
                        phase_tick_next = phase_tick_next + PHASE_W'(1);
                        level_next      = '0;
                    end
                    else
                    begin
                        // End of a repetition: level is left as it was.
                        repeat_index_next = repeat_index_next + 8'd1;
                        if (repeat_index_next < cfg.repetitions)
                            phase_tick_next = '0;
                    end
                end
                else
                begin
                    level_next = '0;
                end
            end
            else
            begin
                // Disarmed: level, pitch trim and position cleared, all direct flags set; roll trim is kept.
                level_next        = '0;
                pitch_trim_next   = '0;
                phase_tick_next   = '0;
                repeat_index_next = '0;
                direct_flags_next = DIRECT_FLAGS_ALL;
            end
        end
    end

    // State update, one step per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_samples_reg   <= '0;
            off_samples_reg  <= COUNT_WIDTH'(OFF_SAMPLES_RST);
            phase_tick_reg   <= '0;
            repeat_index_reg <= '0;
            level_reg        <= '0;
            pitch_trim_reg   <= '0;
            roll_trim_reg    <= '0;
            direct_flags_reg <= DIRECT_FLAGS_RST;
        end
        else if (advance)
        begin
            on_samples_reg   <= on_samples_next;
            off_samples_reg  <= off_samples_next;
            phase_tick_reg   <= phase_tick_next;
            repeat_index_reg <= repeat_index_next;
            level_reg        <= level_next;
            pitch_trim_reg   <= pitch_trim_next;
            roll_trim_reg    <= roll_trim_next;
            direct_flags_reg <= direct_flags_next;
        end
    end

    // Result of this tick.
    always_comb
    begin
        result.start_request          = start_req;
        result.stop_request           = stop_req;
        result.tracking_on            = item.tracking_switch_us > cfg.switch_threshold_us;
        result.step_command           = level_next;
        result.pitch_trim             = pitch_trim_next;
        result.roll_trim              = roll_trim_next;
        result.elevator_follows_stick = direct_flags_next[0];
        result.rudder_follows_stick   = direct_flags_next[1];
        result.throttle_follows_stick = direct_flags_next[2];
    end

endmodule
